[rtl/slc_pkg.sv]
`timescale 1ns / 1ps

package slc_pkg;

  // Sprite table and line geometry
  localparam int SPRITE_COUNT = 64;
  localparam int LINE_WIDTH   = 256;

  // Configuration register indexes
  localparam logic [1:0] REG_TALL_SPRITES    = 2'd0;
  localparam logic [1:0] REG_UPPER_TABLE     = 2'd1;
  localparam logic [1:0] REG_SPRITES_ENABLED = 2'd2;

  typedef enum logic [2:0] {
    ACT_WRITE_ATTR  = 3'd0,
    ACT_WRITE_PAL   = 3'd1,
    ACT_SET_BG      = 3'd2,
    ACT_START_LINE  = 3'd3,
    ACT_PATTERN     = 3'd4,
    ACT_READ_PIXEL  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    KIND_FETCH = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_PIXEL = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_TILE_RD,
    ST_ATTR_RD,
    ST_EMIT,
    ST_DRAW_ATTR,
    ST_DRAW_X,
    ST_DRAW_XCAP,
    ST_PX_RD,
    ST_PX_WR
  } state_e;

endpackage

[rtl/sprite_line_compositor.sv]
`timescale 1ns / 1ps

// Sequence: writes and ignored items complete in idle; a pixel read result is registered
// from the read state, a start with sprites disabled answers at once. Start line / pattern
// reply: a pattern draws 8 pixels, each a read then a write, then each sprite is examined
// by scan read and check; tile read, attribute read and emit form a fetch, or the line closes.
// Throughput: one item at a time; input is ready again in idle once the result slot is free.
// Reset: async active low; a clearing pass zeroes attribute memory and line store.
module sprite_line_compositor (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [0:0]  cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  item_index_i,
  input  logic [7:0]  data_byte_i,
  input  logic [5:0]  bg_color_i,
  input  logic        bg_opaque_i,
  input  logic [7:0]  line_number_i,
  input  logic [7:0]  pattern_low_i,
  input  logic [7:0]  pattern_high_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [12:0] pattern_address_o,
  output logic [5:0]  sprite_number_o,
  output logic [5:0]  pixel_color_o,
  output logic        sprite_zero_hit_o
);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  slc_pkg::state_e state_q, state_d;

  logic       tall_q, upper_q, enabled_q;
  logic [6:0] scan_q;       // next sprite to examine, counts up to SPRITE_COUNT
  logic [7:0] cur_line_q;
  logic [5:0] pend_q;       // sprite whose pattern row is outstanding
  logic       active_q;
  logic       zhit_q;
  logic [2:0] k_q;          // pixel counter while drawing
  logic [7:0] clr_q;        // entry being zeroed by the clearing pass
  logic       out_valid_q;

  // Payload registers
  logic [7:0] idx_q;
  logic [7:0] plo_q, phi_q;
  logic [3:0] row_q;
  logic [7:0] tile_q;
  logic [7:0] attr_q;
  logic [7:0] x0_q;
  logic [1:0]  out_kind_q;
  logic [12:0] out_addr_q;
  logic [5:0]  out_spr_q;
  logic [5:0]  out_color_q;
  logic        out_hit_q;

  // ---------------------------------------------------------------------------
  // Storage. Attribute memory and line store are zeroed by the clearing pass
  // after reset; palette is small and lives in flops.
  // ---------------------------------------------------------------------------
  logic [7:0]   am_mem [256];
  logic [7:0]   am_rd_q;
  logic [7:0]   am_rd;

  logic [7:0]   ls_mem [256];
  logic [7:0]   ls_rd_q;
  logic [7:0]   ls_rd;

  logic [5:0]   pal_q [32];

  // Control decode
  logic        accept;
  logic        slot_free;
  logic [7:0]  am_raddr;
  logic        am_we;
  logic [7:0]  am_waddr;
  logic [7:0]  am_wdata;
  logic [7:0]  ls_addr;
  logic        ls_we;
  logic [7:0]  ls_wdata;
  logic        out_load;
  logic [1:0]  out_kind_d;
  logic [12:0] out_addr_d;
  logic [5:0]  out_spr_d;
  logic [5:0]  out_color_d;
  logic        out_hit_d;

  // Datapath terms
  logic        scan_done;
  logic        covers;
  logic [7:0]  line_delta;
  logic [3:0]  row_f;
  logic [12:0] fetch_addr;
  logic [8:0]  px_x;
  logic [2:0]  px_bit;
  logic [1:0]  px_v;
  logic        px_draw;
  logic [5:0]  pal_color;
  logic        idx_in_line;
  logic        rd_in_line;

  assign am_rd = am_rd_q;
  assign ls_rd = ls_rd_q;

  // The input is taken only in idle and only when the result register is free
  // or drains at this same edge, so every result finds an empty slot.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == slc_pkg::ST_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  assign idx_in_line = {1'b0, item_index_i} < 9'(slc_pkg::LINE_WIDTH);
  assign rd_in_line  = {1'b0, idx_q} < 9'(slc_pkg::LINE_WIDTH);
  assign scan_done   = scan_q == 7'(slc_pkg::SPRITE_COUNT);

  // Coverage: line > y and (line - y - 1) below the sprite height.
  assign line_delta = cur_line_q - am_rd - 8'd1;
  assign covers     = (cur_line_q > am_rd) &&
                      (tall_q ? (line_delta[7:4] == 4'd0) : (line_delta[7:3] == 5'd0));

  // Vertical flip: 15-row for tall sprites, 7-row for short ones.
  always_comb begin
    row_f = row_q;
    if (am_rd[7]) begin
      row_f = tall_q ? ~row_q : {1'b0, 3'd7 - row_q[2:0]};
    end
  end

  // In the emit state the attribute port returns the attribute byte.
  assign fetch_addr = tall_q ? {tile_q[0], tile_q[7:1], row_f[3], 1'b0, row_f[2:0]}
                             : {upper_q, tile_q, row_f};

  // Pixel k of the row: bit 7-k normally, bit k when mirrored.
  assign px_x      = {1'b0, x0_q} + {6'd0, k_q};
  assign px_bit    = attr_q[6] ? k_q : ~k_q;
  assign px_v      = {phi_q[px_bit], plo_q[px_bit]};
  assign pal_color = pal_q[{1'b1, attr_q[1:0], px_v}];
  // First drawn wins: a pixel already marked is left alone.
  assign px_draw   = (px_x < 9'(slc_pkg::LINE_WIDTH)) && (px_v != 2'd0) && !ls_rd[7];

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      slc_pkg::ST_CLEAR:     state_d = (clr_q == 8'd255) ? slc_pkg::ST_IDLE : slc_pkg::ST_CLEAR;
      slc_pkg::ST_IDLE: begin
        if (accept) begin
          case (action_i)
            slc_pkg::ACT_START_LINE: state_d = enabled_q ? slc_pkg::ST_SCAN_RD
                                                         : slc_pkg::ST_IDLE;
            slc_pkg::ACT_PATTERN:    state_d = active_q ? slc_pkg::ST_DRAW_ATTR
                                                        : slc_pkg::ST_IDLE;
            slc_pkg::ACT_READ_PIXEL: state_d = slc_pkg::ST_READ;
            default:                 state_d = slc_pkg::ST_IDLE;
          endcase
        end
      end
      slc_pkg::ST_READ:      state_d = slc_pkg::ST_IDLE;
      slc_pkg::ST_SCAN_RD:   state_d = scan_done ? slc_pkg::ST_IDLE : slc_pkg::ST_SCAN_CHK;
      slc_pkg::ST_SCAN_CHK:  state_d = covers ? slc_pkg::ST_TILE_RD : slc_pkg::ST_SCAN_RD;
      slc_pkg::ST_TILE_RD:   state_d = slc_pkg::ST_ATTR_RD;
      slc_pkg::ST_ATTR_RD:   state_d = slc_pkg::ST_EMIT;
      slc_pkg::ST_EMIT:      state_d = slc_pkg::ST_IDLE;
      slc_pkg::ST_DRAW_ATTR: state_d = slc_pkg::ST_DRAW_X;
      slc_pkg::ST_DRAW_X:    state_d = slc_pkg::ST_DRAW_XCAP;
      slc_pkg::ST_DRAW_XCAP: state_d = slc_pkg::ST_PX_RD;
      slc_pkg::ST_PX_RD:     state_d = slc_pkg::ST_PX_WR;
      slc_pkg::ST_PX_WR:     state_d = (k_q == 3'd7) ? slc_pkg::ST_SCAN_RD : slc_pkg::ST_PX_RD;
      default:               state_d = slc_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer: memory ports and result load
  // ---------------------------------------------------------------------------
  always_comb begin
    am_raddr    = 8'd0;
    am_we       = 1'b0;
    am_waddr    = item_index_i;
    am_wdata    = data_byte_i;
    ls_addr     = item_index_i;
    ls_we       = 1'b0;
    ls_wdata    = {1'b0, bg_opaque_i, bg_color_i};
    out_load    = 1'b0;
    out_kind_d  = slc_pkg::KIND_DONE;
    out_addr_d  = 13'd0;
    out_spr_d   = 6'd0;
    out_color_d = 6'd0;
    out_hit_d   = 1'b0;
    case (state_q)
      slc_pkg::ST_CLEAR: begin
        am_we    = 1'b1;
        am_waddr = clr_q;
        am_wdata = 8'd0;
        ls_we    = 1'b1;
        ls_addr  = clr_q;
        ls_wdata = 8'd0;
      end
      slc_pkg::ST_IDLE: begin
        if (accept) begin
          case (action_i)
            slc_pkg::ACT_WRITE_ATTR: am_we = 1'b1;
            slc_pkg::ACT_SET_BG:     ls_we = idx_in_line;
            slc_pkg::ACT_START_LINE: out_load = !enabled_q;
            default: ;
          endcase
        end
      end
      slc_pkg::ST_READ: begin
        out_load    = 1'b1;
        out_kind_d  = slc_pkg::KIND_PIXEL;
        out_color_d = rd_in_line ? ls_rd[5:0] : 6'd0;
      end
      slc_pkg::ST_SCAN_RD: begin
        am_raddr  = {scan_q[5:0], 2'd0};
        out_load  = scan_done;
        out_hit_d = zhit_q;
      end
      slc_pkg::ST_TILE_RD:   am_raddr = {pend_q, 2'd1};
      slc_pkg::ST_ATTR_RD:   am_raddr = {pend_q, 2'd2};
      slc_pkg::ST_EMIT: begin
        out_load   = 1'b1;
        out_kind_d = slc_pkg::KIND_FETCH;
        out_addr_d = fetch_addr;
        out_spr_d  = pend_q;
      end
      slc_pkg::ST_DRAW_ATTR: am_raddr = {pend_q, 2'd2};
      slc_pkg::ST_DRAW_X:    am_raddr = {pend_q, 2'd3};
      slc_pkg::ST_PX_RD:     ls_addr  = px_x[7:0];
      slc_pkg::ST_PX_WR: begin
        ls_addr  = px_x[7:0];
        ls_we    = px_draw;
        // Over an opaque background pixel, behind-background sprites only mark it.
        ls_wdata = (!attr_q[5] || !ls_rd[6]) ? {2'b10, pal_color} : {1'b1, ls_rd[6:0]};
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (am_we) begin
      am_mem[am_waddr] <= am_wdata;
    end
    am_rd_q <= am_mem[am_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      ls_mem[ls_addr] <= ls_wdata;
    end
    ls_rd_q <= ls_mem[ls_addr];
  end

  // ---------------------------------------------------------------------------
  // Control registers and palette
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slc_pkg::ST_CLEAR;
      tall_q      <= 1'b0;
      upper_q     <= 1'b0;
      enabled_q   <= 1'b1;
      scan_q      <= 7'd0;
      cur_line_q  <= 8'd0;
      pend_q      <= 6'd0;
      active_q    <= 1'b0;
      zhit_q      <= 1'b0;
      k_q         <= 3'd0;
      clr_q       <= 8'd0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        pal_q[i] <= 6'd0;
      end
    end else begin
      state_q <= state_d;

      if (state_q == slc_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 8'd1;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          slc_pkg::REG_TALL_SPRITES:    tall_q    <= cfg_data_i[0];
          slc_pkg::REG_UPPER_TABLE:     upper_q   <= cfg_data_i[0];
          slc_pkg::REG_SPRITES_ENABLED: enabled_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (accept && (action_i == slc_pkg::ACT_WRITE_PAL)) begin
        pal_q[item_index_i[4:0]] <= data_byte_i[5:0];
      end

      if (accept && (action_i == slc_pkg::ACT_START_LINE)) begin
        cur_line_q <= line_number_i;
        scan_q     <= 7'd0;
        pend_q     <= 6'd0;
        zhit_q     <= 1'b0;
        active_q   <= enabled_q;
      end

      if (accept && (action_i == slc_pkg::ACT_PATTERN) && active_q &&
          (pend_q == 6'd0) && ((pattern_low_i | pattern_high_i) != 8'd0)) begin
        zhit_q <= 1'b1;
      end

      if (state_q == slc_pkg::ST_SCAN_RD && scan_done) begin
        active_q <= 1'b0;
      end

      if (state_q == slc_pkg::ST_SCAN_CHK) begin
        scan_q <= scan_q + 7'd1;
        if (covers) begin
          pend_q <= scan_q[5:0];
        end
      end

      if (state_q == slc_pkg::ST_DRAW_XCAP) begin
        k_q <= 3'd0;
      end else if (state_q == slc_pkg::ST_PX_WR) begin
        k_q <= k_q + 3'd1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= item_index_i;
      plo_q <= pattern_low_i;
      phi_q <= pattern_high_i;
    end
    if (state_q == slc_pkg::ST_SCAN_CHK) begin
      row_q <= line_delta[3:0];
    end
    if (state_q == slc_pkg::ST_ATTR_RD) begin
      tile_q <= am_rd;
    end
    if (state_q == slc_pkg::ST_DRAW_X) begin
      attr_q <= am_rd;
    end
    if (state_q == slc_pkg::ST_DRAW_XCAP) begin
      x0_q <= am_rd;
    end
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_addr_q  <= out_addr_d;
      out_spr_q   <= out_spr_d;
      out_color_q <= out_color_d;
      out_hit_q   <= out_hit_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_kind_q;
  assign pattern_address_o = out_addr_q;
  assign sprite_number_o   = out_spr_q;
  assign pixel_color_o     = out_color_q;
  assign sprite_zero_hit_o = out_hit_q;

endmodule

[test/tb_sprite_line_compositor.sv]
`timescale 1ns / 1ps

typedef struct packed {
  logic [2:0] action;
  logic [7:0] item_index;
  logic [7:0] data_byte;
  logic [5:0] bg_color;
  logic       bg_opaque;
  logic [7:0] line_number;
  logic [7:0] pattern_low;
  logic [7:0] pattern_high;
} item_t;

typedef struct packed {
  logic [1:0]  kind;
  logic [12:0] address;
  logic [5:0]  sprite;
  logic [5:0]  color;
  logic        zero_hit;
} answer_t;

class compositor_scoreboard;
  bit [7:0]   oam [256];
  bit [5:0]   palette [32];
  bit [7:0]   line_px [256];  // 5..0 color, 6 opaque bg, 7 sprite drawn
  bit [6:0]   scan_pos;
  bit [7:0]   cur_line;
  bit [5:0]   pend_sprite;
  bit         line_active;
  bit         zero_hit;
  bit         tall;
  bit         upper_tbl;
  bit         enabled;
  answer_t    answers_due[$];
  int unsigned mismatches;

  function new();
    enabled = 1'b1;
  endfunction

  function void set_register(logic [1:0] idx, logic val);
    case (idx)
      slc_pkg::REG_TALL_SPRITES:    tall = val;
      slc_pkg::REG_UPPER_TABLE:     upper_tbl = val;
      slc_pkg::REG_SPRITES_ENABLED: enabled = val;
      default: ;
    endcase
  endfunction

  function int height();
    return tall ? 16 : 8;
  endfunction

  function bit covers(int s);
    int top;
    top = int'(oam[(s * 4) & 255]) + 1;
    return int'(cur_line) >= top && int'(cur_line) < top + height();
  endfunction

  function bit [12:0] fetch_address(int s);
    int h, top, tile, attr, row, addr;
    h    = height();
    top  = int'(oam[(s * 4) & 255]) + 1;
    tile = int'(oam[(s * 4 + 1) & 255]);
    attr = int'(oam[(s * 4 + 2) & 255]);
    row  = (int'(cur_line) - top) & 15;
    if ((attr & 'h80) != 0) row = (h - 1 - row) & 15;
    if (h == 16)
      addr = (tile & 'hFE) * 16 + (tile & 1) * 'h1000 + (row >= 8 ? 16 : 0) + (row & 7);
    else
      addr = (upper_tbl ? 'h1000 : 0) + tile * 16 + row;
    return 13'(addr);
  endfunction

  // next covering sprite gets a fetch; running off the end closes the line
  function void scan_on();
    answer_t a;
    int s;
    a = '0;
    while (scan_pos < slc_pkg::SPRITE_COUNT) begin
      s = int'(scan_pos);
      scan_pos++;
      if (covers(s)) begin
        pend_sprite = 6'(s);
        a.kind      = slc_pkg::KIND_FETCH;
        a.address   = fetch_address(s);
        a.sprite    = 6'(s);
        answers_due.push_back(a);
        return;
      end
    end
    line_active = 1'b0;
    a.kind      = slc_pkg::KIND_DONE;
    a.zero_hit  = zero_hit;
    answers_due.push_back(a);
  endfunction

  function void draw(bit [7:0] lo, bit [7:0] hi);
    int s, attr, x0, upper, k, b, v, x;
    bit behind, mirror;
    s      = int'(pend_sprite);
    attr   = int'(oam[(s * 4 + 2) & 255]);
    x0     = int'(oam[(s * 4 + 3) & 255]);
    upper  = (attr & 3) << 2;
    behind = (attr & 'h20) != 0;
    mirror = (attr & 'h40) != 0;
    for (k = 0; k < 8; k++) begin
      b = mirror ? k : 7 - k;
      v = int'(lo[b]) + 2 * int'(hi[b]);
      x = x0 + k;
      if (x >= slc_pkg::LINE_WIDTH || v == 0) continue;
      if (line_px[x][7]) continue;
      if (!behind || !line_px[x][6]) line_px[x] = {2'b00, palette[(16 | upper | v) & 31]};
      line_px[x][7] = 1'b1;
    end
  endfunction

  // returns 0 for items the block ignores
  function bit apply_item(item_t it);
    answer_t a;
    a = '0;
    case (it.action)
      slc_pkg::ACT_WRITE_ATTR: oam[it.item_index] = it.data_byte;
      slc_pkg::ACT_WRITE_PAL:  palette[it.item_index[4:0]] = it.data_byte[5:0];
      slc_pkg::ACT_SET_BG: begin
        if (it.item_index < slc_pkg::LINE_WIDTH)
          line_px[it.item_index] = {1'b0, it.bg_opaque, it.bg_color};
      end
      slc_pkg::ACT_START_LINE: begin
        cur_line    = it.line_number;
        scan_pos    = '0;
        pend_sprite = '0;
        zero_hit    = 1'b0;
        if (!enabled) begin
          line_active = 1'b0;
          a.kind      = slc_pkg::KIND_DONE;
          answers_due.push_back(a);
        end else begin
          line_active = 1'b1;
          scan_on();
        end
      end
      slc_pkg::ACT_PATTERN: begin
        if (!line_active) return 1'b0;
        draw(it.pattern_low, it.pattern_high);
        if (pend_sprite == 0 && (it.pattern_low | it.pattern_high) != 0) zero_hit = 1'b1;
        scan_on();
      end
      slc_pkg::ACT_READ_PIXEL: begin
        a.kind  = slc_pkg::KIND_PIXEL;
        a.color = (it.item_index < slc_pkg::LINE_WIDTH) ? line_px[it.item_index][5:0] : 6'd0;
        answers_due.push_back(a);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task report_mismatch(string msg);
    if (mismatches < 50) $display("%0t ns  MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task check_answer(answer_t got);
    answer_t want;
    if (answers_due.size() == 0) begin
      report_mismatch($sformatf("answer of kind %0d with none due", got.kind));
      return;
    end
    want = answers_due.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.address !== want.address)
      report_mismatch($sformatf("pattern_address %h, want %h", got.address, want.address));
    if (got.sprite !== want.sprite)
      report_mismatch($sformatf("sprite_number %0d, want %0d", got.sprite, want.sprite));
    if (got.color !== want.color)
      report_mismatch($sformatf("pixel_color %0d, want %0d", got.color, want.color));
    if (got.zero_hit !== want.zero_hit)
      report_mismatch($sformatf("sprite_zero_hit %0d, want %0d", got.zero_hit, want.zero_hit));
  endtask
endclass

module tb_sprite_line_compositor;

  // Codes with no meaning to the block; they must pass without an answer.
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 196;
  // Worst single item: 64 sprites scanned, fetch setup, 8-pixel draw.
  localparam int SETTLE_CYCLES   = 200;
  localparam int LONG_HOLD       = 400;
  localparam int WATCHDOG_LIMIT  = 4000;

  // Register settings per phase, bit p for phase p (all-zero and all-one included).
  localparam bit [NUM_PHASES-1:0] TALL_BY_PHASE   = 6'b010010;
  localparam bit [NUM_PHASES-1:0] UPPER_BY_PHASE  = 6'b110100;
  localparam bit [NUM_PHASES-1:0] ENABLE_BY_PHASE = 6'b110111;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_index_i    = '0;
  logic [0:0]  cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic [2:0]  action_i       = '0;
  logic [7:0]  item_index_i   = '0;
  logic [7:0]  data_byte_i    = '0;
  logic [5:0]  bg_color_i     = '0;
  logic        bg_opaque_i    = 1'b0;
  logic [7:0]  line_number_i  = '0;
  logic [7:0]  pattern_low_i  = '0;
  logic [7:0]  pattern_high_i = '0;
  logic        out_ready_i    = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  kind_o;
  logic [12:0] pattern_address_o;
  logic [5:0]  sprite_number_o;
  logic [5:0]  pixel_color_o;
  logic        sprite_zero_hit_o;

  compositor_scoreboard sb;
  int unsigned tx_idle_pct   = 0;  // sender gap chance per cycle, percent
  int unsigned rx_idle_pct   = 0;  // receiver stall chance per cycle, percent
  int unsigned items_done    = 0;  // transfers the block acted on
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  sprite_line_compositor i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .item_index_i      (item_index_i),
    .data_byte_i       (data_byte_i),
    .bg_color_i        (bg_color_i),
    .bg_opaque_i       (bg_opaque_i),
    .line_number_i     (line_number_i),
    .pattern_low_i     (pattern_low_i),
    .pattern_high_i    (pattern_high_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .pattern_address_o (pattern_address_o),
    .sprite_number_o   (sprite_number_o),
    .pixel_color_o     (pixel_color_o),
    .sprite_zero_hit_o (sprite_zero_hit_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side: check each transfer, then pick next ready. A pending long hold
  // overrides the random stalls so the block backs up into its input.
  always @(posedge clk_i) begin : rx_side
    answer_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind     = kind_o;
      got.address  = pattern_address_o;
      got.sprite   = sprite_number_o;
      got.color    = pixel_color_o;
      got.zero_hit = sprite_zero_hit_o;
      sb.check_answer(got);
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog: any transfer on either side resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item and hold it until the transfer. Valid stays up between
  // back-to-back items; a gap drops it between them.
  task automatic send_item(item_t it);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid_i     <= 1'b1;
    action_i       <= it.action;
    item_index_i   <= it.item_index;
    data_byte_i    <= it.data_byte;
    bg_color_i     <= it.bg_color;
    bg_opaque_i    <= it.bg_opaque;
    line_number_i  <= it.line_number;
    pattern_low_i  <= it.pattern_low;
    pattern_high_i <= it.pattern_high;
    do @(posedge clk_i); while (!in_ready_o);
    if (sb.apply_item(it)) items_done++;
  endtask

  // a/b/c land in the fields the action uses; every other field is random
  // so the block is seen to ignore it.
  task automatic send_op(logic [2:0] act, logic [7:0] a, logic [7:0] b, logic [7:0] c);
    item_t it;
    it.action       = act;
    it.item_index   = 8'($urandom);
    it.data_byte    = 8'($urandom);
    it.bg_color     = 6'($urandom);
    it.bg_opaque    = 1'($urandom);
    it.line_number  = 8'($urandom);
    it.pattern_low  = 8'($urandom);
    it.pattern_high = 8'($urandom);
    case (act)
      slc_pkg::ACT_WRITE_ATTR, slc_pkg::ACT_WRITE_PAL: begin
        it.item_index = a;
        it.data_byte  = b;
      end
      slc_pkg::ACT_SET_BG: begin
        it.item_index = a;
        it.bg_color   = b[5:0];
        it.bg_opaque  = c[0];
      end
      slc_pkg::ACT_START_LINE: it.line_number = a;
      slc_pkg::ACT_PATTERN: begin
        it.pattern_low  = a;
        it.pattern_high = b;
      end
      slc_pkg::ACT_READ_PIXEL: it.item_index = a;
      default: ;
    endcase
    send_item(it);
  endtask

  // Answer fetches until the line closes (random pattern rows).
  task automatic close_line();
    while (sb.line_active)
      send_op(slc_pkg::ACT_PATTERN, 8'($urandom), 8'($urandom), 8'h00);
  endtask

  // Drop valid, let every due answer arrive, then give the block time to
  // finish any write still in flight.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (sb.answers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.set_register(idx, val);
  endtask

  // One well-formed line: place a few sprites around the chosen line (some one
  // row outside it), load palette and background, start, answer every fetch,
  // read back the touched pixels. Now and then the line is restarted or
  // dropped halfway.
  task automatic compose_random_line();
    int line_no, h, n, base_x, r, s, k;
    line_no = $urandom_range(0, 255);
    h       = sb.tall ? 16 : 8;
    n       = $urandom_range(1, 5);
    base_x  = ($urandom_range(0, 7) == 0) ? $urandom_range(240, 255) : $urandom_range(0, 255);
    for (k = 0; k < n; k++) begin
      s = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 63);
      r = int'($urandom_range(0, h + 1)) - 1;
      send_op(slc_pkg::ACT_WRITE_ATTR, 8'(s * 4), 8'(line_no - 1 - r), 8'h00);
      send_op(slc_pkg::ACT_WRITE_ATTR, 8'(s * 4 + 1), 8'($urandom), 8'h00);
      send_op(slc_pkg::ACT_WRITE_ATTR, 8'(s * 4 + 2), 8'($urandom), 8'h00);
      send_op(slc_pkg::ACT_WRITE_ATTR, 8'(s * 4 + 3), 8'(base_x + $urandom_range(0, 7)),
              8'h00);
    end
    repeat ($urandom_range(1, 3))
      send_op(slc_pkg::ACT_WRITE_PAL, 8'($urandom), 8'($urandom), 8'h00);
    for (k = 0; k < 16; k++)
      if ($urandom_range(0, 3) != 0)
        send_op(slc_pkg::ACT_SET_BG, 8'(base_x + k), 8'($urandom), 8'($urandom));
    send_op(slc_pkg::ACT_START_LINE, 8'(line_no), 8'h00, 8'h00);
    while (sb.line_active) begin
      if ($urandom_range(0, 39) == 0) break;
      if ($urandom_range(0, 39) == 0)
        send_op(slc_pkg::ACT_START_LINE, 8'($urandom), 8'h00, 8'h00);
      else if ($urandom_range(0, 4) == 0)
        send_op(slc_pkg::ACT_PATTERN, 8'h00, 8'h00, 8'h00);
      else
        send_op(slc_pkg::ACT_PATTERN, 8'($urandom), 8'($urandom), 8'h00);
    end
    repeat ($urandom_range(2, 8))
      send_op(slc_pkg::ACT_READ_PIXEL, 8'(base_x + $urandom_range(0, 11)), 8'h00, 8'h00);
  endtask

  initial begin
    int p;
    int unsigned target;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset register values, no idling.
    // Palette index wraps: 0xF1 lands on entry 0x11.
    send_op(slc_pkg::ACT_WRITE_PAL, 8'hF1, 8'hFF, 8'h00);
    send_op(slc_pkg::ACT_WRITE_PAL, 8'h1F, 8'hC5, 8'h00);
    // Sprite 0 on lines 10..17, mirrored and behind bg, x 252 so half is cut.
    send_op(slc_pkg::ACT_WRITE_ATTR, 8'd0, 8'd9,   8'h00);
    send_op(slc_pkg::ACT_WRITE_ATTR, 8'd1, 8'hFF,  8'h00);
    send_op(slc_pkg::ACT_WRITE_ATTR, 8'd2, 8'h63,  8'h00);
    send_op(slc_pkg::ACT_WRITE_ATTR, 8'd3, 8'hFC,  8'h00);
    // Sprite 63, vertically flipped, at x 0.
    send_op(slc_pkg::ACT_WRITE_ATTR, 8'd252, 8'd9,  8'h00);
    send_op(slc_pkg::ACT_WRITE_ATTR, 8'd253, 8'h00, 8'h00);
    send_op(slc_pkg::ACT_WRITE_ATTR, 8'd254, 8'h80, 8'h00);
    send_op(slc_pkg::ACT_WRITE_ATTR, 8'd255, 8'h00, 8'h00);
    send_op(slc_pkg::ACT_SET_BG, 8'hFF, 8'h3F, 8'h01);
    send_op(slc_pkg::ACT_SET_BG, 8'h00, 8'h00, 8'h00);
    // pattern with no line, then the two spare codes: no answers
    send_op(slc_pkg::ACT_PATTERN, 8'hAA, 8'h55, 8'h00);
    send_op(ACT_SPARE_6, 8'hFF, 8'hFF, 8'hFF);
    send_op(ACT_SPARE_7, 8'h00, 8'h00, 8'h00);
    // second start abandons the first
    send_op(slc_pkg::ACT_START_LINE, 8'd10, 8'h00, 8'h00);
    send_op(slc_pkg::ACT_START_LINE, 8'd10, 8'h00, 8'h00);
    send_op(slc_pkg::ACT_PATTERN, 8'hFF, 8'h00, 8'h00);
    send_op(slc_pkg::ACT_PATTERN, 8'hFF, 8'hFF, 8'h00);
    send_op(slc_pkg::ACT_READ_PIXEL, 8'hFF, 8'h00, 8'h00);
    send_op(slc_pkg::ACT_READ_PIXEL, 8'hFC, 8'h00, 8'h00);
    send_op(slc_pkg::ACT_READ_PIXEL, 8'h00, 8'h00, 8'h00);
    send_op(slc_pkg::ACT_READ_PIXEL, 8'h07, 8'h00, 8'h00);
    // last line: nothing covers it
    send_op(slc_pkg::ACT_START_LINE, 8'd255, 8'h00, 8'h00);

    // Random phases: new register values each, idling sender-light then
    // receiver-light then none.
    for (p = 0; p < NUM_PHASES; p++) begin
      close_line();
      wait_quiet();
      write_reg(slc_pkg::REG_TALL_SPRITES, TALL_BY_PHASE[p]);
      write_reg(slc_pkg::REG_UPPER_TABLE, UPPER_BY_PHASE[p]);
      write_reg(slc_pkg::REG_SPRITES_ENABLED, ENABLE_BY_PHASE[p]);
      write_reg(REG_SPARE, 1'b1);
      cfg_we_i <= 1'b0;
      if (p < 2) begin
        tx_idle_pct = 11;
        rx_idle_pct = 57;
      end else if (p < 4) begin
        tx_idle_pct = 57;
        rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 0) hold_requests++;
      target = items_done + ITEMS_PER_PHASE;
      while (items_done < target) begin
        if ($urandom_range(0, 9) < 7)
          compose_random_line();
        else
          repeat ($urandom_range(1, 4))
            send_op(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    close_line();
    wait_quiet();

    if (sb.mismatches == 0 && sb.answers_due.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[sprite_line_compositor.f]
rtl/slc_pkg.sv
rtl/sprite_line_compositor.sv
test/tb_sprite_line_compositor.sv
